/* rtl/gsg_pkg.sv */
// Shared types and constants for the Gray-Scott grid engine.
// No dependencies; imported by gsg_ctrl, gsg_datapath and the top level.
package gsg_pkg;

  localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
  localparam logic [1:0] REG_FEED_RATE   = 2'd2;
  localparam logic [1:0] REG_KILL_RATE   = 2'd3;

  localparam logic [7:0]  GRID_WIDTH_RST  = 8'd128;
  localparam logic [7:0]  GRID_HEIGHT_RST = 8'd128;
  localparam logic [15:0] FEED_RATE_RST   = 16'd3604;
  localparam logic [15:0] KILL_RATE_RST   = 16'd4063;

  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2,
    KIND_RUN   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    TAP_CENTER = 2'd0,
    TAP_EDGE   = 2'd1,
    TAP_DIAG   = 2'd2
  } tap_t;

  typedef struct packed {
    logic load_item;
    logic mem_rd;
    logic acc_en;
    tap_t tap;
    logic wr_clear;
    logic wr_cell;
    logic wr_new;
    logic calc_go;
    logic rsp_load;
    logic rsp_read;
    logic rsp_err;
  } gsg_cmd_t;

  typedef struct packed {
    logic calc_done;
    logic out_busy;
  } gsg_sts_t;

endpackage

/* rtl/gsg_datapath.sv */
// Datapath: double-banked concentration memory, Laplacian accumulators,
// five-stage cell update pipeline and result register. Uses gsg_pkg.
module gsg_datapath #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128,
  parameter int VALUE_BITS = 16,
  parameter int IDX_W      = 14
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  gsg_pkg::gsg_cmd_t        cmd,
  output gsg_pkg::gsg_sts_t        sts,
  input  logic [IDX_W:0]           mem_addr,
  input  logic signed [15:0]       in_value_a,
  input  logic signed [15:0]       in_value_b,
  input  logic [15:0]              feed_rate,
  input  logic [15:0]              kill_rate,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [15:0]       out_read_a,
  output logic signed [15:0]       out_read_b,
  output logic                     out_index_error
);
  import gsg_pkg::*;

  localparam int V     = VALUE_BITS;
  localparam int F     = V - 2;
  localparam int ACC_W = 2 * V + 8;
  localparam int IO_UP = (V >= 16) ? V - 16 : 0;
  localparam int IO_DN = (V < 16) ? 16 - V : 0;
  localparam int SH_UP = (F < 17) ? 17 - F : 0;
  localparam int SH_DN = (F > 17) ? F - 17 : 0;
  localparam int DEPTH = 2 ** (IDX_W + 1);

  localparam logic signed [V-1:0]     ONE_V   = V'(1) <<< F;
  localparam logic signed [V:0]       ONE_X   = (V + 1)'(1) <<< F;
  localparam logic signed [16:0]      W_EDGE  = 17'sd13107;
  localparam logic signed [16:0]      W_DIAG  = 17'sd3277;
  localparam logic signed [ACC_W-1:0] BB_HALF = ACC_W'(1) <<< (F - 1);
  localparam logic signed [ACC_W-1:0] RND17   = ACC_W'(65536);
  localparam logic signed [ACC_W-1:0] SAT_HI  = (ACC_W'(1) <<< (V - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] SAT_LO  = -SAT_HI - ACC_W'(1);

  function automatic logic signed [V-1:0] sat_v(input logic signed [ACC_W-1:0] x);
    logic signed [V-1:0] r;
    if (x > SAT_HI) r = SAT_HI[V-1:0];
    else if (x < SAT_LO) r = SAT_LO[V-1:0];
    else r = x[V-1:0];
    return r;
  endfunction

  logic [2*V-1:0]         mem_r [0:DEPTH-1];
  logic [2*V-1:0]         rdata_r;
  logic [2*V-1:0]         wdata;
  logic                   wr_en;
  logic signed [V-1:0]    wa_r, wb_r;
  logic signed [V-1:0]    rd_a, rd_b;
  logic                   tap_vld_r;
  tap_t                   tap_r;
  logic signed [V-1:0]    c_a_r, c_b_r;
  logic signed [V+1:0]    esa_r, esb_r, dsa_r, dsb_r;

  logic signed [V+18:0]   pea_w, pda_w, peb_w, pdb_w;
  logic signed [2*V-1:0]  bsq_w;
  logic signed [V:0]      oma_w;
  logic signed [16:0]     feed_s;
  logic signed [17:0]     fk_s;
  logic signed [V+17:0]   pf_w;
  logic signed [V+18:0]   pk_w;
  logic signed [2*V+1:0]  p_w;
  logic signed [ACC_W-1:0] abb;

  logic                   v1_r, v2_r, v3_r, v4_r, v5_r;
  logic signed [ACC_W-1:0] pea_r, pda_r, peb_r, pdb_r, bsq_r, pf_r, pk_r;
  logic signed [ACC_W-1:0] la_r, lb_r, p_r, ta_r, tb_r;
  logic signed [V+1:0]    bb_r;
  logic signed [V-1:0]    na_r, nb_r;

  logic                   out_valid_r, out_err_r;
  logic signed [15:0]     out_a_r, out_b_r;

  assign rd_a = rdata_r[2*V-1:V];
  assign rd_b = rdata_r[V-1:0];

  assign wr_en = cmd.wr_clear | cmd.wr_cell | cmd.wr_new;
  always_comb begin
    if (cmd.wr_clear) wdata = {ONE_V, V'(0)};
    else if (cmd.wr_cell) wdata = {wa_r, wb_r};
    else wdata = {na_r, nb_r};
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[mem_addr] <= wdata;
    if (cmd.mem_rd) rdata_r <= mem_r[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      wa_r <= V'((32'(in_value_a) <<< IO_UP) >>> IO_DN);
      wb_r <= V'((32'(in_value_b) <<< IO_UP) >>> IO_DN);
    end
    tap_r <= cmd.tap;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) tap_vld_r <= 1'b0;
    else tap_vld_r <= cmd.mem_rd & cmd.acc_en;
  end

  always_ff @(posedge clk) begin
    if (tap_vld_r) begin
      case (tap_r)
        TAP_CENTER: begin
          c_a_r <= rd_a;
          c_b_r <= rd_b;
          esa_r <= '0;
          esb_r <= '0;
          dsa_r <= '0;
          dsb_r <= '0;
        end
        TAP_EDGE: begin
          esa_r <= esa_r + (V + 2)'(rd_a);
          esb_r <= esb_r + (V + 2)'(rd_b);
        end
        default: begin
          dsa_r <= dsa_r + (V + 2)'(rd_a);
          dsb_r <= dsb_r + (V + 2)'(rd_b);
        end
      endcase
    end
  end

  assign pea_w  = esa_r * W_EDGE;
  assign pda_w  = dsa_r * W_DIAG;
  assign peb_w  = esb_r * W_EDGE;
  assign pdb_w  = dsb_r * W_DIAG;
  assign bsq_w  = c_b_r * c_b_r;
  assign oma_w  = ONE_X - (V + 1)'(c_a_r);
  assign feed_s = {1'b0, feed_rate};
  assign fk_s   = {2'b00, feed_rate} + {2'b00, kill_rate};
  assign pf_w   = feed_s * oma_w;
  assign pk_w   = fk_s * c_b_r;
  assign p_w    = c_a_r * bb_r;
  assign abb    = (p_r <<< SH_UP) >>> SH_DN;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= cmd.calc_go;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_go) begin
      pea_r <= ACC_W'(pea_w);
      pda_r <= ACC_W'(pda_w);
      peb_r <= ACC_W'(peb_w);
      pdb_r <= ACC_W'(pdb_w);
      bsq_r <= ACC_W'(bsq_w);
      pf_r  <= ACC_W'(pf_w);
      pk_r  <= ACC_W'(pk_w);
    end
    if (v1_r) begin
      la_r <= pea_r + pda_r - (ACC_W'(c_a_r) <<< 16);
      lb_r <= peb_r + pdb_r - (ACC_W'(c_b_r) <<< 16);
      bb_r <= (V + 2)'((bsq_r + BB_HALF) >>> F);
    end
    if (v2_r) p_r <= ACC_W'(p_w);
    if (v3_r) begin
      ta_r <= (ACC_W'(c_a_r) <<< 17) + (la_r <<< 1) - abb + (pf_r <<< 1);
      tb_r <= (ACC_W'(c_b_r) <<< 17) + lb_r + abb - (pk_r <<< 1);
    end
    if (v4_r) begin
      na_r <= sat_v((ta_r + RND17) >>> 17);
      nb_r <= sat_v((tb_r + RND17) >>> 17);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.rsp_load) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.rsp_load) begin
      out_a_r   <= cmd.rsp_read ? 16'((32'(rd_a) >>> IO_UP) <<< IO_DN) : 16'sd0;
      out_b_r   <= cmd.rsp_read ? 16'((32'(rd_b) >>> IO_UP) <<< IO_DN) : 16'sd0;
      out_err_r <= cmd.rsp_err;
    end
  end

  assign sts.calc_done   = v5_r;
  assign sts.out_busy    = out_valid_r & ~out_ready;
  assign out_valid       = out_valid_r;
  assign out_read_a      = out_a_r;
  assign out_read_b      = out_b_r;
  assign out_index_error = out_err_r;

endmodule

/* rtl/gsg_ctrl.sv */
// Controller: item sequencing, grid sweep counters, neighbor address
// generation and bank select. Uses gsg_pkg; drives gsg_datapath commands.
module gsg_ctrl #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128,
  parameter int IDX_W      = 14
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_kind,
  input  logic [13:0]         in_cell_index,
  input  logic [15:0]         in_iteration_count,
  input  logic [7:0]          grid_width,
  input  logic [7:0]          grid_height,
  output gsg_pkg::gsg_cmd_t   cmd,
  input  gsg_pkg::gsg_sts_t   sts,
  output logic [IDX_W:0]      mem_addr
);
  import gsg_pkg::*;

  localparam int XW    = $clog2(MAX_WIDTH + 1);
  localparam int YW    = $clog2(MAX_HEIGHT + 1);
  localparam int AW    = XW + YW;
  localparam int CW    = (AW > 14) ? AW : 14;
  localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam logic [IDX_W-1:0] CNT_LAST  = IDX_W'(CELLS - 1);
  localparam logic [3:0]       STEP_LAST = 4'd8;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_CLEAR    = 10'b0000000010,
    S_WRITE    = 10'b0000000100,
    S_READ     = 10'b0000001000,
    S_RUN_RD   = 10'b0000010000,
    S_RUN_GAP  = 10'b0000100000,
    S_RUN_CALC = 10'b0001000000,
    S_RUN_WAIT = 10'b0010000000,
    S_RUN_WR   = 10'b0100000000,
    S_RESP     = 10'b1000000000
  } state_t;

  state_t            state_r, state_nxt;
  kind_t             kind_r, kind_nxt;
  logic [13:0]       cell_r, cell_nxt;
  logic              bad_r, bad_nxt;
  logic [15:0]       iter_r, iter_nxt;
  logic [XW-1:0]     x_r, x_nxt;
  logic [YW-1:0]     y_r, y_nxt;
  logic [3:0]        step_r, step_nxt;
  logic [IDX_W-1:0]  cnt_r, cnt_nxt;
  logic              bank_r, bank_nxt;

  logic [XW-1:0]     w, xm, xp, col_sel;
  logic [YW-1:0]     h, ym, yp, row_sel;
  logic [AW-1:0]     area;
  logic              in_bad;
  logic [IDX_W-1:0]  lin;
  tap_t              tap_sel;

  always_comb begin
    if (grid_width == 8'd0) w = XW'(1);
    else if (32'(grid_width) > MAX_WIDTH) w = XW'(MAX_WIDTH);
    else w = XW'(grid_width);
    if (grid_height == 8'd0) h = YW'(1);
    else if (32'(grid_height) > MAX_HEIGHT) h = YW'(MAX_HEIGHT);
    else h = YW'(grid_height);
  end

  assign area   = AW'(w) * AW'(h);
  assign in_bad = CW'(in_cell_index) >= CW'(area);

  assign xm = (x_r == '0) ? w - XW'(1) : x_r - XW'(1);
  assign xp = (x_r + XW'(1) < w) ? x_r + XW'(1) : '0;
  assign ym = (y_r == '0) ? h - YW'(1) : y_r - YW'(1);
  assign yp = (y_r + YW'(1) < h) ? y_r + YW'(1) : '0;

  always_comb begin
    row_sel = y_r;
    col_sel = x_r;
    tap_sel = TAP_DIAG;
    unique case (step_r)
      4'd0: tap_sel = TAP_CENTER;
      4'd1: begin row_sel = ym; tap_sel = TAP_EDGE; end
      4'd2: begin row_sel = yp; tap_sel = TAP_EDGE; end
      4'd3: begin col_sel = xm; tap_sel = TAP_EDGE; end
      4'd4: begin col_sel = xp; tap_sel = TAP_EDGE; end
      4'd5: begin row_sel = ym; col_sel = xm; end
      4'd6: begin row_sel = ym; col_sel = xp; end
      4'd7: begin row_sel = yp; col_sel = xm; end
      4'd8: begin row_sel = yp; col_sel = xp; end
      default: tap_sel = TAP_CENTER;
    endcase
  end

  assign lin = IDX_W'(AW'(row_sel) * AW'(w) + AW'(col_sel));

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    cell_nxt  = cell_r;
    bad_nxt   = bad_r;
    iter_nxt  = iter_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    step_nxt  = step_r;
    cnt_nxt   = cnt_r;
    bank_nxt  = bank_r;
    cmd       = '0;
    mem_addr  = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          kind_nxt = kind_t'(in_kind);
          cell_nxt = in_cell_index;
          bad_nxt  = in_bad;
          iter_nxt = in_iteration_count;
          x_nxt    = '0;
          y_nxt    = '0;
          step_nxt = '0;
          cnt_nxt  = '0;
          unique case (kind_t'(in_kind))
            KIND_CLEAR: state_nxt = S_CLEAR;
            KIND_WRITE: state_nxt = in_bad ? S_RESP : S_WRITE;
            KIND_READ:  state_nxt = in_bad ? S_RESP : S_READ;
            default:    state_nxt = (in_iteration_count == '0) ? S_RESP : S_RUN_RD;
          endcase
        end
      end
      S_CLEAR: begin
        cmd.wr_clear = 1'b1;
        mem_addr = {bank_r, cnt_r};
        if (cnt_r == CNT_LAST) state_nxt = S_RESP;
        else cnt_nxt = cnt_r + IDX_W'(1);
      end
      S_WRITE: begin
        cmd.wr_cell = 1'b1;
        mem_addr = {bank_r, IDX_W'(cell_r)};
        state_nxt = S_RESP;
      end
      S_READ: begin
        cmd.mem_rd = 1'b1;
        mem_addr = {bank_r, IDX_W'(cell_r)};
        state_nxt = S_RESP;
      end
      S_RUN_RD: begin
        cmd.mem_rd = 1'b1;
        cmd.acc_en = 1'b1;
        cmd.tap    = tap_sel;
        mem_addr   = {bank_r, lin};
        if (step_r == STEP_LAST) begin
          step_nxt  = '0;
          state_nxt = S_RUN_GAP;
        end else begin
          step_nxt = step_r + 4'd1;
        end
      end
      S_RUN_GAP: state_nxt = S_RUN_CALC;
      S_RUN_CALC: begin
        cmd.calc_go = 1'b1;
        state_nxt = S_RUN_WAIT;
      end
      S_RUN_WAIT: begin
        if (sts.calc_done) state_nxt = S_RUN_WR;
      end
      S_RUN_WR: begin
        cmd.wr_new = 1'b1;
        mem_addr = {~bank_r, lin};
        state_nxt = S_RUN_RD;
        if (x_r == w - XW'(1)) begin
          x_nxt = '0;
          if (y_r == h - YW'(1)) begin
            y_nxt    = '0;
            bank_nxt = ~bank_r;
            iter_nxt = iter_r - 16'd1;
            if (iter_r == 16'd1) state_nxt = S_RESP;
          end else begin
            y_nxt = y_r + YW'(1);
          end
        end else begin
          x_nxt = x_r + XW'(1);
        end
      end
      S_RESP: begin
        if (!sts.out_busy) begin
          cmd.rsp_load = 1'b1;
          cmd.rsp_read = (kind_r == KIND_READ) & ~bad_r;
          cmd.rsp_err  = bad_r & ((kind_r == KIND_READ) | (kind_r == KIND_WRITE));
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      bank_r  <= 1'b0;
      iter_r  <= '0;
      x_r     <= '0;
      y_r     <= '0;
      step_r  <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      bank_r  <= bank_nxt;
      iter_r  <= iter_nxt;
      x_r     <= x_nxt;
      y_r     <= y_nxt;
      step_r  <= step_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    cell_r <= cell_nxt;
    bad_r  <= bad_nxt;
  end

endmodule

/* rtl/gray_scott_grid_engine_core.sv */
// Gray-Scott grid engine top level: configuration registers, controller, datapath.
// Clear writes all MAX_WIDTH*MAX_HEIGHT cells of the current bank; write/read with a bad
// index skip the memory access; run makes nine single-port memory reads per cell plus
// the five-stage update pipeline; one item at a time, result held in an output register.
// Reset (synchronous, rst_n low) restores the register defaults and bank 0;
// grid memory contents are undefined until cleared or written.
module gray_scott_grid_engine_core #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128,
  parameter int VALUE_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_kind,
  input  logic [13:0]        in_cell_index,
  input  logic signed [15:0] in_value_a,
  input  logic signed [15:0] in_value_b,
  input  logic [15:0]        in_iteration_count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_read_a,
  output logic signed [15:0] out_read_b,
  output logic               out_index_error,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import gsg_pkg::*;

  localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int IDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;

  logic [7:0]      grid_width_r, grid_height_r;
  logic [15:0]     feed_rate_r, kill_rate_r;
  gsg_cmd_t        cmd;
  gsg_sts_t        sts;
  logic [IDX_W:0]  mem_addr;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= GRID_WIDTH_RST;
      grid_height_r <= GRID_HEIGHT_RST;
      feed_rate_r   <= FEED_RATE_RST;
      kill_rate_r   <= KILL_RATE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:  grid_width_r  <= cfg_data[7:0];
        REG_GRID_HEIGHT: grid_height_r <= cfg_data[7:0];
        REG_FEED_RATE:   feed_rate_r   <= cfg_data;
        REG_KILL_RATE:   kill_rate_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  gsg_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .IDX_W      (IDX_W)
  ) u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_kind            (in_kind),
    .in_cell_index      (in_cell_index),
    .in_iteration_count (in_iteration_count),
    .grid_width         (grid_width_r),
    .grid_height        (grid_height_r),
    .cmd                (cmd),
    .sts                (sts),
    .mem_addr           (mem_addr)
  );

  gsg_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .VALUE_BITS (VALUE_BITS),
    .IDX_W      (IDX_W)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .mem_addr        (mem_addr),
    .in_value_a      (in_value_a),
    .in_value_b      (in_value_b),
    .feed_rate       (feed_rate_r),
    .kill_rate       (kill_rate_r),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_read_a      (out_read_a),
    .out_read_b      (out_read_b),
    .out_index_error (out_index_error)
  );

endmodule

/* tb/sv/tb_gray_scott_grid_engine_core.sv */
// Self-checking testbench for gray_scott_grid_engine_core: directed and random items,
// checked against an in-bench Gray-Scott grid predictor. Depends on rtl/gsg_pkg.sv
// and the core RTL only.
module tb_gray_scott_grid_engine_core;
  timeunit 1ns;
  timeprecision 1ps;
  import gsg_pkg::*;

  localparam int  CELLS      = 128 * 128;
  localparam int  SIDE_MAX   = 128;
  localparam int  HOLD_LEN   = 400;
  localparam int  TAIL_WAIT  = 60;
  localparam longint LIMIT   = 40_000_000;

  localparam int MODE_FREE  = 0;
  localparam int MODE_SEND  = 1;
  localparam int MODE_RECV  = 2;
  localparam int MODE_BOTH  = 3;

  typedef struct {
    logic signed [15:0] read_a;
    logic signed [15:0] read_b;
    logic               index_error;
  } cell_result_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_kind;
  logic [13:0]        in_cell_index;
  logic signed [15:0] in_value_a;
  logic signed [15:0] in_value_b;
  logic [15:0]        in_iteration_count;
  logic               out_valid;
  logic               out_ready;
  logic signed [15:0] out_read_a;
  logic signed [15:0] out_read_b;
  logic               out_index_error;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [15:0]        cfg_data;

  cell_result_t pending_results[$];
  longint       cycles;
  longint       hold_until;
  int           idle_mode;
  int           errors;

  // predictor state
  longint conc_a[2*CELLS];
  longint conc_b[2*CELLS];
  bit     bank;
  int     width_reg, height_reg, feed_reg, kill_reg;

  gray_scott_grid_engine_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind),
    .in_cell_index(in_cell_index), .in_value_a(in_value_a), .in_value_b(in_value_b),
    .in_iteration_count(in_iteration_count),
    .out_valid(out_valid), .out_ready(out_ready), .out_read_a(out_read_a),
    .out_read_b(out_read_b), .out_index_error(out_index_error),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb_gray_scott_grid_engine_core: errors");
      $finish;
    end
  end

  function automatic int eff_size(int v);
    if (v == 0) return 1;
    return v > SIDE_MAX ? SIDE_MAX : v;
  endfunction

  function automatic longint sat16(longint x);
    if (x > 32767) return 32767;
    if (x < -32768) return -32768;
    return x;
  endfunction

  function automatic longint laplacian(bit use_b, int base, int w, int x, int y,
                                       int xm, int xp, int ym, int yp);
    longint e, d, c;
    if (use_b) begin
      e = conc_b[base+ym*w+x] + conc_b[base+yp*w+x] + conc_b[base+y*w+xm]
        + conc_b[base+y*w+xp];
      d = conc_b[base+ym*w+xm] + conc_b[base+ym*w+xp] + conc_b[base+yp*w+xm]
        + conc_b[base+yp*w+xp];
      c = conc_b[base+y*w+x];
    end else begin
      e = conc_a[base+ym*w+x] + conc_a[base+yp*w+x] + conc_a[base+y*w+xm]
        + conc_a[base+y*w+xp];
      d = conc_a[base+ym*w+xm] + conc_a[base+ym*w+xp] + conc_a[base+yp*w+xm]
        + conc_a[base+yp*w+xp];
      c = conc_a[base+y*w+x];
    end
    return e * 13107 + d * 3277 - c * 65536;
  endfunction

  function automatic void sweep_grid(int w, int h);
    int src, dst, xm, xp, ym, yp, idx;
    longint a, b, la, lb, bb, abb, ta, tb, fk;
    src = bank * CELLS;
    dst = (bank ^ 1'b1) * CELLS;
    fk  = longint'(feed_reg) + kill_reg;
    for (int y = 0; y < h; y++) begin
      ym = (y != 0) ? y - 1 : h - 1;
      yp = (y + 1 < h) ? y + 1 : 0;
      for (int x = 0; x < w; x++) begin
        xm  = (x != 0) ? x - 1 : w - 1;
        xp  = (x + 1 < w) ? x + 1 : 0;
        idx = y * w + x;
        a   = conc_a[src+idx];
        b   = conc_b[src+idx];
        la  = laplacian(0, src, w, x, y, xm, xp, ym, yp);
        lb  = laplacian(1, src, w, x, y, xm, xp, ym, yp);
        bb  = (b * b + 8192) >>> 14;
        abb = a * bb * 8;
        ta  = a * 131072 + 2 * la - abb + 2 * longint'(feed_reg) * (16384 - a);
        tb  = b * 131072 + lb + abb - 2 * fk * b;
        conc_a[dst+idx] = sat16((ta + 65536) >>> 17);
        conc_b[dst+idx] = sat16((tb + 65536) >>> 17);
      end
    end
    bank = ~bank;
  endfunction

  function automatic cell_result_t predict_cell(kind_t k, int idx, logic signed [15:0] va,
                                                logic signed [15:0] vb, int count);
    cell_result_t r;
    int w, h, base;
    w    = eff_size(width_reg);
    h    = eff_size(height_reg);
    base = bank * CELLS;
    r    = '{0, 0, 0};
    case (k)
      KIND_CLEAR: begin
        for (int i = 0; i < CELLS; i++) begin
          conc_a[base+i] = 16384;
          conc_b[base+i] = 0;
        end
      end
      KIND_WRITE: begin
        if (idx >= w * h) r.index_error = 1;
        else begin
          conc_a[base+idx] = va;
          conc_b[base+idx] = vb;
        end
      end
      KIND_READ: begin
        if (idx >= w * h) r.index_error = 1;
        else begin
          r.read_a = conc_a[base+idx][15:0];
          r.read_b = conc_b[base+idx][15:0];
        end
      end
      default: for (int i = 0; i < count; i++) sweep_grid(w, h);
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (cycles < hold_until) out_ready <= 1'b0;
    else case (idle_mode)
      MODE_RECV: out_ready <= ($urandom_range(0, 99) >= 71);
      MODE_BOTH: out_ready <= ($urandom_range(0, 99) >= 16);
      default:   out_ready <= 1'b1;
    endcase
  end

  always @(posedge clk) begin
    cell_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: a=%0d b=%0d err=%0b", $time,
                 out_read_a, out_read_b, out_index_error);
      end else begin
        e = pending_results.pop_front();
        if (out_read_a !== e.read_a) begin
          errors++;
          $display("%0t: read_a expected %0d actual %0d", $time, e.read_a, out_read_a);
        end
        if (out_read_b !== e.read_b) begin
          errors++;
          $display("%0t: read_b expected %0d actual %0d", $time, e.read_b, out_read_b);
        end
        if (out_index_error !== e.index_error) begin
          errors++;
          $display("%0t: index_error expected %0b actual %0b", $time, e.index_error,
                   out_index_error);
        end
      end
    end
  end

  task automatic send_item(kind_t k, int idx = 0, logic signed [15:0] va = 0,
                           logic signed [15:0] vb = 0, int count = 0);
    int gap;
    int pct;
    gap = 0;
    pct = (idle_mode == MODE_SEND) ? 71 : (idle_mode == MODE_BOTH) ? 16 : 0;
    while ($urandom_range(0, 99) < pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_kind            <= k;
    in_cell_index      <= idx[13:0];
    in_value_a         <= va;
    in_value_b         <= vb;
    in_iteration_count <= count[15:0];
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_cell(k, idx, va, vb, count));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[15:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_GRID_WIDTH:  width_reg  = value & 8'hFF;
      REG_GRID_HEIGHT: height_reg = value & 8'hFF;
      REG_FEED_RATE:   feed_reg   = value & 16'hFFFF;
      default:         kill_reg   = value & 16'hFFFF;
    endcase
  endtask

  task automatic set_grid(int w, int h, int feed, int kill);
    write_reg(REG_GRID_WIDTH, w);
    write_reg(REG_GRID_HEIGHT, h);
    write_reg(REG_FEED_RATE, feed);
    write_reg(REG_KILL_RATE, kill);
  endtask

  function automatic int cell_count();
    return eff_size(width_reg) * eff_size(height_reg);
  endfunction

  task automatic test_directed();
    idle_mode = MODE_FREE;
    set_grid(4, 3, 0, 65535);
    send_item(KIND_CLEAR);
    send_item(KIND_READ, 5);
    send_item(KIND_WRITE, 0, -16'sd32768, 16'sd32767);
    send_item(KIND_WRITE, 11, 16'sd32767, -16'sd32768);
    send_item(KIND_WRITE, 5, 16'sd8192, 16'sd4096);
    send_item(KIND_READ, 0);
    send_item(KIND_READ, 11);
    send_item(KIND_WRITE, 16383, -16'sd1, -16'sd1);
    send_item(KIND_READ, 16383);
    send_item(KIND_READ, 12);
    send_item(KIND_RUN, 0, 0, 0, 0);
    send_item(KIND_READ, 5);
    send_item(KIND_RUN, 0, 0, 0, 2);
    send_item(KIND_READ, 0);
    send_item(KIND_READ, 5);
    drain();
    set_grid(0, 255, 65535, 0);
    send_item(KIND_CLEAR);
    send_item(KIND_WRITE, 127, 16'sd100, 16'sd16384);
    send_item(KIND_READ, 127);
    send_item(KIND_READ, 128);
    send_item(KIND_RUN, 0, 0, 0, 1);
    send_item(KIND_READ, 64);
    drain();
    set_grid(255, 0, 3604, 4063);
    send_item(KIND_CLEAR);
    send_item(KIND_READ, 127);
    send_item(KIND_READ, 128);
    drain();
  endtask

  // a single-cell grid keeps the full-range iteration count affordable
  task automatic test_max_iterations();
    idle_mode = MODE_FREE;
    set_grid(1, 1, $urandom_range(0, 65535), $urandom_range(0, 65535));
    send_item(KIND_CLEAR);
    send_item(KIND_WRITE, 0, $urandom, $urandom);
    send_item(KIND_RUN, 0, 0, 0, 16'hFFFF);
    send_item(KIND_READ, 0);
    drain();
  endtask

  task automatic test_random(int mode, int n_items);
    int sel, n;
    idle_mode = mode;
    case ($urandom_range(0, 3))
      0:       set_grid($urandom_range(1, 6), $urandom_range(1, 6), 0, 0);
      1:       set_grid($urandom_range(1, 6), $urandom_range(1, 6), 65535, 65535);
      default: set_grid($urandom_range(1, 6), $urandom_range(1, 6),
                        $urandom_range(0, 65535), $urandom_range(0, 65535));
    endcase
    send_item(KIND_CLEAR);
    n = cell_count();
    for (int i = 0; i < n_items; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 35)      send_item(KIND_WRITE, $urandom_range(0, n - 1), $urandom, $urandom);
      else if (sel < 70) send_item(KIND_READ, $urandom_range(0, n - 1));
      else if (sel < 80) send_item(($urandom_range(0, 1) != 0) ? KIND_WRITE : KIND_READ,
                                   $urandom_range(n, 16383), $urandom, $urandom);
      else if (sel < 96) send_item(KIND_RUN, 0, 0, 0, $urandom_range(0, 3));
      else               send_item(KIND_CLEAR);
    end
    drain();
  endtask

  task automatic test_backpressure();
    int n;
    idle_mode = MODE_FREE;
    set_grid(3, 2, 5000, 3000);
    send_item(KIND_CLEAR);
    drain();
    n = cell_count();
    hold_until = cycles + HOLD_LEN;
    for (int i = 0; i < 10; i++) begin
      if (i % 2 == 0) send_item(KIND_WRITE, $urandom_range(0, n - 1), $urandom, $urandom);
      else            send_item(KIND_READ, $urandom_range(0, n - 1));
    end
    drain();
    send_item(KIND_RUN, 0, 0, 0, 1);
    for (int i = 0; i < n; i++) send_item(KIND_READ, i);
    drain();
  endtask

  initial begin
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_kind            = KIND_CLEAR;
    in_cell_index      = '0;
    in_value_a         = '0;
    in_value_b         = '0;
    in_iteration_count = '0;
    out_ready          = 1'b0;
    cfg_valid          = 1'b0;
    cfg_index          = REG_GRID_WIDTH;
    cfg_data           = '0;
    cycles             = 0;
    hold_until         = 0;
    idle_mode          = MODE_FREE;
    errors             = 0;
    bank               = 0;
    width_reg          = GRID_WIDTH_RST;
    height_reg         = GRID_HEIGHT_RST;
    feed_reg           = FEED_RATE_RST;
    kill_reg           = KILL_RATE_RST;
    foreach (conc_a[i]) begin
      conc_a[i] = 0;
      conc_b[i] = 0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_max_iterations();
    test_random(MODE_FREE, 15);
    test_random(MODE_SEND, 15);
    test_random(MODE_RECV, 15);
    test_random(MODE_BOTH, 15);
    test_backpressure();
    if (errors == 0 && pending_results.size() == 0)
      $display("tb_gray_scott_grid_engine_core: clean");
    else
      $display("tb_gray_scott_grid_engine_core: errors");
    $finish;
  end

endmodule

/* sim.f */
rtl/gsg_pkg.sv
rtl/gsg_datapath.sv
rtl/gsg_ctrl.sv
rtl/gray_scott_grid_engine_core.sv
tb/sv/tb_gray_scott_grid_engine_core.sv
